// ===== rtl/bam_pkg.sv =====
// ----------------------------------------------------------------------------
// bam_pkg
// Shared constants for the binary angle modulation RGB LED driver.
// ----------------------------------------------------------------------------
package bam_pkg;

  localparam int BAM_BITS   = 8;
  localparam int SLOT_W     = (BAM_BITS > 1) ? $clog2(BAM_BITS) : 1;
  localparam int CARRIER_W  = 16;
  localparam int LEVEL_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [CARRIER_W-1:0] CARRIER_RESET = CARRIER_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CARRIER = 2'd0,
    REG_GREEN   = 2'd1,
    REG_RED     = 2'd2,
    REG_BLUE    = 2'd3
  } cfg_reg_t;

endpackage

// ===== rtl/bam_channel.sv =====
// ----------------------------------------------------------------------------
// bam_channel
// One LED channel slot sequencer: slot index, slot countdown and pin latch.
// ----------------------------------------------------------------------------
module bam_channel (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           tick,
  input  logic [bam_pkg::LEVEL_W-1:0]    level,
  input  logic [bam_pkg::CARRIER_W-1:0]  carrier,
  output logic                           pin
);
  import bam_pkg::*;

  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic [CARRIER_W-1:0] rem_r, rem_nxt;
  logic                 pin_r, pin_nxt;

  logic [BAM_BITS-1:0]  level_ext;
  logic [SLOT_W-1:0]    bitpos;
  logic [SLOT_W:0]      shamt;
  logic [CARRIER_W-1:0] len;

  assign level_ext = BAM_BITS'(level);
  assign bitpos    = SLOT_W'(BAM_BITS - 1) - slot_r;
  assign shamt     = {1'b0, slot_r} + (SLOT_W+1)'(1);
  assign len       = carrier >> shamt;

  always_comb begin
    slot_nxt = slot_r;
    rem_nxt  = rem_r;
    pin_nxt  = pin_r;
    if (tick) begin
      if (rem_r > CARRIER_W'(1)) begin
        rem_nxt = rem_r - CARRIER_W'(1);
      end else begin
        pin_nxt = level_ext[bitpos];
        rem_nxt = (len == '0) ? CARRIER_W'(1) : len;
        if (slot_r == SLOT_W'(BAM_BITS - 1)) begin
          slot_nxt = '0;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      rem_r  <= CARRIER_W'(1);
      pin_r  <= 1'b0;
    end else begin
      slot_r <= slot_nxt;
      rem_r  <= rem_nxt;
      pin_r  <= pin_nxt;
    end
  end

  assign pin = pin_nxt;

endmodule

// ===== rtl/bam_rgb_led_modulator.sv =====
// ----------------------------------------------------------------------------
// bam_rgb_led_modulator
// Three-channel binary angle modulation LED driver (green, red, blue).
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per microsecond tick; in_tdata[0] = tick_enable.
//           A request with tick_enable low holds all state and reports pins.
//   out_* : one request per input request carrying the three pin levels.
//   cfg_* : register writes (0 carrier, 1 green, 2 red, 3 blue level),
//           always accepted; they apply at each channel's next slot expiry.
// out_tvalid rises in the cycle after input accept. Throughput is one request
// per cycle while out_tready stays high; the per-channel countdown and reload
// update in the same cycle the request is taken, feeding a single output register.
// in_tready is high while the output register is empty or being drained,
// so a stalled receiver stops input after one buffered result and no
// request is dropped or repeated.
// Reset clears slot indexes, loads each countdown with one (first tick
// expires), clears pins and levels and sets the carrier to 256 ticks.
// ----------------------------------------------------------------------------
module bam_rgb_led_modulator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [bam_pkg::IN_TDATA_W-1:0]      in_tdata,   // [0] tick_enable
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [bam_pkg::OUT_TDATA_W-1:0]     out_tdata,  // [0] green, [1] red, [2] blue
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bam_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bam_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bam_pkg::*;

  logic [CARRIER_W-1:0] carrier_r;
  logic [LEVEL_W-1:0]   green_r, red_r, blue_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           pins_r;
  logic [2:0]           pins;
  logic                 in_acc;
  logic                 tick;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign tick      = in_acc && in_tdata[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_r <= CARRIER_RESET;
      green_r   <= '0;
      red_r     <= '0;
      blue_r    <= '0;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_CARRIER: carrier_r <= cfg_data[CARRIER_W-1:0];
        REG_GREEN:   green_r   <= cfg_data[LEVEL_W-1:0];
        REG_RED:     red_r     <= cfg_data[LEVEL_W-1:0];
        REG_BLUE:    blue_r    <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  bam_channel u_green (
    .clk(clk), .rst_n(rst_n), .tick(tick),
    .level(green_r), .carrier(carrier_r), .pin(pins[0])
  );
  bam_channel u_red (
    .clk(clk), .rst_n(rst_n), .tick(tick),
    .level(red_r), .carrier(carrier_r), .pin(pins[1])
  );
  bam_channel u_blue (
    .clk(clk), .rst_n(rst_n), .tick(tick),
    .level(blue_r), .carrier(carrier_r), .pin(pins[2])
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pins_r <= pins;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(pins_r);

endmodule
